@@ rtl/pfb_pkg.sv @@
// shared types and constants of the period to frequency converter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pfb_pkg;

    // word widths
    localparam int PFB_DATA_W  = 32;
    localparam int PFB_DIGIT_W = 4;
    localparam int PFB_DIGITS  = 4;
    localparam int PFB_BCD_W   = PFB_DIGIT_W * PFB_DIGITS;

    // one cell per quotient bit
    localparam int PFB_CELLS   = PFB_DATA_W;

    // configuration port
    localparam int PFB_ADDR_W  = 1;
    localparam int PFB_PDATA_W = 32;
    localparam logic [PFB_ADDR_W-1:0] PFB_REG_REFERENCE_HZ = 1'b0;

    // reset value of the reference rate
    localparam logic [PFB_DATA_W-1:0] PFB_REF_RESET = 32'd60000000;

    // data handed from one divider cell to the next
    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic [PFB_DATA_W-1:0] rem;
        logic [PFB_DATA_W-1:0] divisor;
        logic [PFB_DATA_W-1:0] dq;
        logic [PFB_BCD_W-1:0]  bcd;
    } t_cell_data;

endpackage

@@ rtl/pfb_cell.sv @@
// one cell of the divider chain: one restoring division step and one
// double-dabble step on the quotient bit it produces; uses pfb_pkg
`timescale 1ns / 1ps

module pfb_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfb_pkg::t_cell_data i_cell,
    output pfb_pkg::t_cell_data o_cell
);
    import pfb_pkg::*;

    logic [PFB_DATA_W:0]   w_trial;
    logic [PFB_DATA_W:0]   w_diff;
    logic                  w_qbit;
    logic [PFB_BCD_W-1:0]  w_adj;
    t_cell_data            n_cell;
    t_cell_data            r_cell;

    // shift in the next dividend bit and try the subtraction
    assign w_trial = {i_cell.rem, i_cell.dq[PFB_DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, i_cell.divisor};
    assign w_qbit  = (w_trial >= {1'b0, i_cell.divisor});

    // add three to every bcd digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < PFB_DIGITS; d++) begin
            if (i_cell.bcd[d*PFB_DIGIT_W +: PFB_DIGIT_W] >= PFB_DIGIT_W'(5)) begin
                w_adj[d*PFB_DIGIT_W +: PFB_DIGIT_W] =
                    i_cell.bcd[d*PFB_DIGIT_W +: PFB_DIGIT_W] + PFB_DIGIT_W'(3);
            end else begin
                w_adj[d*PFB_DIGIT_W +: PFB_DIGIT_W] =
                    i_cell.bcd[d*PFB_DIGIT_W +: PFB_DIGIT_W];
            end
        end
    end

    // next cell contents; the carry out of the thousands digit is dropped
    always_comb begin
        n_cell         = i_cell;
        n_cell.rem     = w_qbit ? w_diff[PFB_DATA_W-1:0] : w_trial[PFB_DATA_W-1:0];
        n_cell.dq      = {i_cell.dq[PFB_DATA_W-2:0], w_qbit};
        n_cell.bcd     = {w_adj[PFB_BCD_W-2:0], w_qbit};
    end

    // valid is cleared by reset, the payload is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
        r_cell.zero    <= n_cell.zero;
        r_cell.rem     <= n_cell.rem;
        r_cell.divisor <= n_cell.divisor;
        r_cell.dq      <= n_cell.dq;
        r_cell.bcd     <= n_cell.bcd;
    end

    assign o_cell = r_cell;

endmodule

@@ rtl/period_to_frequency_bcd.sv @@
// top level of the period to frequency converter with bcd digits
// depends on pfb_pkg and pfb_cell
`timescale 1ns / 1ps
// a word accepted at a clock edge passes the 32 cell registers and the result
//   register, then is on the result ports, one cycle wide, marked by o_done
// throughput: one word per cycle, set by the 32-cell divider chain that
//   resolves one quotient bit and one bcd shift per cell; busy stays low
// reset: synchronous active low, clears the chain valid flags and the result
//   strobe and sets reference_hz to 60000000; the receiver cannot stall results

module period_to_frequency_bcd (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic [pfb_pkg::PFB_DATA_W-1:0]   i_period,
    // results
    output logic                             o_done,
    output logic [pfb_pkg::PFB_DATA_W-1:0]   o_frequency,
    output logic [pfb_pkg::PFB_DIGIT_W-1:0]  o_digit_ones,
    output logic [pfb_pkg::PFB_DIGIT_W-1:0]  o_digit_tens,
    output logic [pfb_pkg::PFB_DIGIT_W-1:0]  o_digit_hundreds,
    output logic [pfb_pkg::PFB_DIGIT_W-1:0]  o_digit_thousands,
    output logic                             o_zero_period,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pfb_pkg::PFB_ADDR_W-1:0]   paddr,
    input  logic [pfb_pkg::PFB_PDATA_W-1:0]  pwdata,
    output logic [pfb_pkg::PFB_PDATA_W-1:0]  prdata,
    output logic                             pready
);
    import pfb_pkg::*;

    logic [PFB_DATA_W-1:0]  r_reference_hz;
    logic                   w_cfg_wr;
    t_cell_data             w_chain [0:PFB_CELLS];
    t_cell_data             w_last;

    logic                   r_done;
    logic [PFB_DATA_W-1:0]  r_frequency;
    logic [PFB_BCD_W-1:0]   r_bcd;
    logic                   r_zero_period;

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference_hz <= PFB_REF_RESET;
        end else if (w_cfg_wr && (paddr == PFB_REG_REFERENCE_HZ)) begin
            r_reference_hz <= pwdata;
        end
    end

    assign prdata = (paddr == PFB_REG_REFERENCE_HZ) ? r_reference_hz : '0;

    // the chain takes a new word every cycle
    assign busy = 1'b0;

    // head of the chain: dividend in dq, remainder and digits empty
    always_comb begin
        w_chain[0].valid   = start && !busy;
        w_chain[0].zero    = (i_period == '0);
        w_chain[0].rem     = '0;
        w_chain[0].divisor = i_period;
        w_chain[0].dq      = r_reference_hz;
        w_chain[0].bcd     = '0;
    end

    // one cell per quotient bit, most significant first
    for (genvar g = 0; g < PFB_CELLS; g++) begin : g_cell
        pfb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    assign w_last = w_chain[PFB_CELLS];

    // result register; a zero period forces the frequency and the digits to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero_period <= w_last.zero;
        r_frequency   <= w_last.zero ? '0 : w_last.dq;
        r_bcd         <= w_last.zero ? '0 : w_last.bcd;
    end

    assign o_done            = r_done;
    assign o_frequency       = r_frequency;
    assign o_zero_period     = r_zero_period;
    assign o_digit_ones      = r_bcd[0*PFB_DIGIT_W +: PFB_DIGIT_W];
    assign o_digit_tens      = r_bcd[1*PFB_DIGIT_W +: PFB_DIGIT_W];
    assign o_digit_hundreds  = r_bcd[2*PFB_DIGIT_W +: PFB_DIGIT_W];
    assign o_digit_thousands = r_bcd[3*PFB_DIGIT_W +: PFB_DIGIT_W];

endmodule

@@ rtl/pfb_chk.sv @@
// port-level checker of the period to frequency converter and its bind
// depends on pfb_pkg and period_to_frequency_bcd
`timescale 1ns / 1ps

module pfb_chk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             o_done,
    input  logic [pfb_pkg::PFB_DATA_W-1:0]   o_frequency,
    input  logic [pfb_pkg::PFB_DIGIT_W-1:0]  o_digit_ones,
    input  logic [pfb_pkg::PFB_DIGIT_W-1:0]  o_digit_tens,
    input  logic [pfb_pkg::PFB_DIGIT_W-1:0]  o_digit_hundreds,
    input  logic [pfb_pkg::PFB_DIGIT_W-1:0]  o_digit_thousands,
    input  logic                             o_zero_period
);
    import pfb_pkg::*;

    // every accepted word comes out of the chain marked by o_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##33 o_done)
        else $error("accepted word did not complete after 33 cycles");

    // digits are decimal whenever o_done is high
    a_bcd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_digit_ones <= 4'd9) && (o_digit_tens <= 4'd9) &&
                   (o_digit_hundreds <= 4'd9) && (o_digit_thousands <= 4'd9))
        else $error("result digit out of decimal range");

    // zero period gives an all-zero word
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_zero_period) |-> (o_frequency == '0) &&
            (o_digit_ones == '0) && (o_digit_tens == '0) &&
            (o_digit_hundreds == '0) && (o_digit_thousands == '0))
        else $error("zero period word carries nonzero fields");

    // a frequency below ten shows in the ones digit, with a zero tens digit
    a_small_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_frequency < PFB_DATA_W'(10))) |->
            (o_digit_ones == o_frequency[PFB_DIGIT_W-1:0]) && (o_digit_tens == '0))
        else $error("digits do not match a single-digit frequency");

endmodule

bind period_to_frequency_bcd pfb_chk u_pfb_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_frequency       (o_frequency),
    .o_digit_ones      (o_digit_ones),
    .o_digit_tens      (o_digit_tens),
    .o_digit_hundreds  (o_digit_hundreds),
    .o_digit_thousands (o_digit_thousands),
    .o_zero_period     (o_zero_period)
);
